/* design/acr_pkg.sv */
// Shared types, constants and helpers for the AABB collision resolver.
package acr_pkg;

    localparam int DEF_MAX_BOXES    = 64;
    localparam int DEF_MAX_SUBSTEPS = 16;

    localparam int FT_W   = 16;
    localparam int EXT_W  = 24;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int CIDX_W = 3;

    localparam logic signed [31:0] RST_FLOOR   = -32'sd88474;
    localparam logic signed [31:0] RST_CEILING = 32'sd88474;
    localparam logic [30:0]        RST_SUBDIST = 31'd6554;
    localparam logic [30:0]        RST_TOL     = 31'd9830;
    localparam logic [CNT_W-1:0]   RST_BOXCNT  = '0;

    localparam logic [CIDX_W-1:0] CFG_FLOOR   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CEILING = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SUBDIST = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TOL     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BOXCNT  = 3'd4;

    localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

    typedef enum logic [1:0] {
        AX_X,
        AX_Z,
        AX_Y
    } t_axis;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_LATCH,
        OP_MAXD,
        OP_CNT,
        OP_DIVINIT,
        OP_DIV,
        OP_MUL,
        OP_ADD,
        OP_FLOOR,
        OP_CEIL,
        OP_WALK,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op   op;
        t_axis axis;
        logic  eval;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_done;
    } t_dp_stat;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        logic signed [31:0] hz;
    } t_box;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > S32_MAX) begin
            return 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] half32(input logic signed [31:0] s);
        logic signed [31:0] t;
        t = s + {31'd0, s[31]};
        return t >>> 1;
    endfunction

endpackage

/* design/acr_datapath.sv */
// Datapath: box table, substep count and divide, move and push-out arithmetic.
module acr_datapath #(
    parameter int MAX_BOXES    = acr_pkg::DEF_MAX_BOXES,
    parameter int MAX_SUBSTEPS = acr_pkg::DEF_MAX_SUBSTEPS,
    parameter int AW           = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int SW           = $clog2(MAX_SUBSTEPS + 1)
) (
    input  logic                        i_clk,
    input  acr_pkg::t_dp_cmd            i_cmd_dp,
    output acr_pkg::t_dp_stat           o_stat,
    output logic [SW-1:0]               o_steps,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic signed [31:0]          i_floor,
    input  logic signed [31:0]          i_ceiling,
    input  logic [30:0]                 i_subdist,
    input  logic [30:0]                 i_tol,
    input  logic [acr_pkg::IDX_W-1:0]   i_box_index,
    input  logic signed [31:0]          i_first_x,
    input  logic signed [31:0]          i_first_y,
    input  logic signed [31:0]          i_first_z,
    input  logic signed [31:0]          i_second_x,
    input  logic signed [31:0]          i_second_y,
    input  logic signed [31:0]          i_second_z,
    input  logic [acr_pkg::EXT_W-1:0]   i_entity_radius,
    input  logic [acr_pkg::EXT_W-1:0]   i_entity_height,
    input  logic [acr_pkg::FT_W-1:0]    i_frame_time,
    output logic signed [31:0]          o_new_x,
    output logic signed [31:0]          o_new_y,
    output logic signed [31:0]          o_new_z,
    output logic signed [31:0]          o_new_vel_y,
    output logic                        o_grounded,
    output logic                        o_substeps_clamped
);
    import acr_pkg::*;

    localparam int AC_W = 31 + SW;

    t_box mem [MAX_BOXES];

    logic signed [31:0] r_px, r_py, r_pz, r_vx, r_vy, r_vz, r_prev_y;
    logic [EXT_W-1:0]   r_r, r_h;
    logic [FT_W-1:0]    r_ft, r_q;
    logic [31:0]        r_vmax, r_maxd;
    logic [AC_W-1:0]    r_acc;
    logic [SW-1:0]      r_k;
    logic [SW:0]        r_rem;
    logic               r_clamped, r_grounded;
    logic signed [48:0] r_prod;
    t_box               r_box;
    logic signed [31:0] r_ox, r_oy, r_oz, r_ovy;
    logic               r_og, r_oc;

    logic [30:0]        sd_eff;
    logic [31:0]        ax, ay, az, vmax;
    logic               cnt_less;
    logic [SW:0]        rem_s;
    logic               ge;
    logic signed [31:0] v_sel, p_sel;
    logic signed [48:0] prod;
    logic signed [35:0] travel, sum;
    logic signed [35:0] rr, hh, tt, px, py, pz, pvy;
    logic signed [35:0] lox, hix, loy, hiy, loz, hiz;
    logic               ovl;
    logic [47:0]        mprod;

    assign sd_eff = (i_subdist == '0) ? 31'd1 : i_subdist;
    assign ax = i_second_x[31] ? 32'(-i_second_x) : i_second_x;
    assign ay = i_second_y[31] ? 32'(-i_second_y) : i_second_y;
    assign az = i_second_z[31] ? 32'(-i_second_z) : i_second_z;
    assign vmax = (ax >= ay) ? ((ax >= az) ? ax : az) : ((ay >= az) ? ay : az);
    assign mprod = 48'(r_vmax) * 48'(r_ft);

    assign cnt_less = r_acc < AC_W'(r_maxd);
    assign o_stat.cnt_done = !cnt_less || (r_k == SW'(MAX_SUBSTEPS));
    assign o_steps = r_k;

    assign rem_s = {r_rem[SW-1:0], r_q[FT_W-1]};
    assign ge = rem_s >= {1'b0, r_k};

    always_comb begin
        case (i_cmd_dp.axis)
            AX_X:    begin v_sel = r_vx; p_sel = r_px; end
            AX_Z:    begin v_sel = r_vz; p_sel = r_pz; end
            default: begin v_sel = r_vy; p_sel = r_py; end
        endcase
    end

    assign prod   = 49'(v_sel) * 49'($signed({1'b0, r_q}));
    assign travel = 36'($signed(r_prod[48:16]));
    assign sum    = 36'(p_sel) + travel;

    assign rr  = 36'($signed({1'b0, r_r}));
    assign hh  = 36'($signed({1'b0, r_h}));
    assign tt  = 36'($signed({1'b0, i_tol}));
    assign px  = 36'(r_px);
    assign py  = 36'(r_py);
    assign pz  = 36'(r_pz);
    assign pvy = 36'(r_prev_y);
    assign lox = 36'(r_box.cx) - 36'(r_box.hx);
    assign hix = 36'(r_box.cx) + 36'(r_box.hx);
    assign loy = 36'(r_box.cy) - 36'(r_box.hy);
    assign hiy = 36'(r_box.cy) + 36'(r_box.hy);
    assign loz = 36'(r_box.cz) - 36'(r_box.hz);
    assign hiz = 36'(r_box.cz) + 36'(r_box.hz);
    assign ovl = (px + rr > lox) && (px - rr < hix) && (py + hh > loy) && (py < hiy)
              && (pz + rr > loz) && (pz - rr < hiz);

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.op == OP_LOAD && 32'(i_box_index) < MAX_BOXES) begin
            mem[AW'(i_box_index)] <= '{cx: i_first_x, cy: i_first_y, cz: i_first_z,
                                       hx: half32(i_second_x), hy: half32(i_second_y),
                                       hz: half32(i_second_z)};
        end
        if (i_rd_en) begin
            r_box <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd_dp.op)
            OP_LATCH: begin
                r_px <= i_first_x;  r_py <= i_first_y;  r_pz <= i_first_z;
                r_vx <= i_second_x; r_vy <= i_second_y; r_vz <= i_second_z;
                r_r  <= i_entity_radius;
                r_h  <= i_entity_height;
                r_ft <= i_frame_time;
                r_vmax <= vmax;
            end
            OP_MAXD: begin
                r_maxd <= mprod[47:16];
                r_acc  <= AC_W'(sd_eff);
                r_k    <= SW'(1);
            end
            OP_CNT: begin
                r_acc <= r_acc + AC_W'(sd_eff);
                r_k   <= r_k + SW'(1);
            end
            OP_DIVINIT: begin
                r_clamped <= cnt_less;
                r_q       <= r_ft;
                r_rem     <= '0;
            end
            OP_DIV: begin
                r_rem <= ge ? (rem_s - {1'b0, r_k}) : rem_s;
                r_q   <= {r_q[FT_W-2:0], ge};
            end
            OP_MUL: begin
                r_prod <= prod;
                if (i_cmd_dp.axis == AX_Y) begin
                    r_prev_y <= r_py;
                end
            end
            OP_ADD: begin
                case (i_cmd_dp.axis)
                    AX_X: r_px <= sat32(sum);
                    AX_Z: r_pz <= sat32(sum);
                    default: begin
                        r_py       <= sat32(sum);
                        r_grounded <= 1'b0;
                    end
                endcase
            end
            OP_FLOOR: begin
                if (r_py <= i_floor) begin
                    r_py       <= i_floor;
                    r_vy       <= '0;
                    r_grounded <= 1'b1;
                end
            end
            OP_CEIL: begin
                if (py + hh >= 36'(i_ceiling)) begin
                    r_py <= sat32(36'(i_ceiling) - hh);
                    if (r_vy > 0) begin
                        r_vy <= '0;
                    end
                end
            end
            OP_WALK: begin
                if (i_cmd_dp.eval && ovl) begin
                    case (i_cmd_dp.axis)
                        AX_X: r_px <= (r_px < r_box.cx) ? sat32(lox - rr) : sat32(hix + rr);
                        AX_Z: r_pz <= (r_pz < r_box.cz) ? sat32(loz - rr) : sat32(hiz + rr);
                        default: begin
                            if (r_vy <= 0 && pvy >= hiy - tt) begin
                                r_py       <= sat32(hiy);
                                r_vy       <= '0;
                                r_grounded <= 1'b1;
                            end else if (r_vy > 0 && pvy + hh <= loy + tt) begin
                                r_py <= sat32(loy - hh);
                                r_vy <= '0;
                            end
                        end
                    endcase
                end
            end
            OP_OUT: begin
                r_ox <= r_px; r_oy <= r_py; r_oz <= r_pz; r_ovy <= r_vy;
                r_og <= r_grounded;
                r_oc <= r_clamped;
            end
            default: begin
            end
        endcase
    end

    assign o_new_x            = r_ox;
    assign o_new_y            = r_oy;
    assign o_new_z            = r_oz;
    assign o_new_vel_y        = r_ovy;
    assign o_grounded         = r_og;
    assign o_substeps_clamped = r_oc;

endmodule

/* design/acr_ctrl.sv */
// Controller: sequences load, substep setup, per-axis moves and box walks.
module acr_ctrl #(
    parameter int MAX_BOXES    = acr_pkg::DEF_MAX_BOXES,
    parameter int MAX_SUBSTEPS = acr_pkg::DEF_MAX_SUBSTEPS,
    parameter int AW           = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int SW           = $clog2(MAX_SUBSTEPS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_cmd,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [acr_pkg::CNT_W-1:0]  i_box_count,
    input  logic [SW-1:0]              i_steps,
    input  acr_pkg::t_dp_stat          i_stat,
    output acr_pkg::t_dp_cmd           o_cmd_dp,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr
);
    import acr_pkg::*;

    localparam int NW = $clog2(MAX_BOXES + 1);
    localparam int DW = $clog2(FT_W);

    typedef enum logic [3:0] {
        S_IDLE, S_MAXD, S_CNT, S_DIV, S_MUL, S_ADD, S_FLOOR, S_CEIL, S_WALK, S_OUT
    } t_state;

    t_state          r_state;
    t_axis           r_axis;
    logic [NW-1:0]   r_bidx;
    logic            r_eval;
    logic [DW-1:0]   r_div;
    logic [SW-1:0]   r_sub;
    logic            r_out_valid;
    logic [NW-1:0]   n_lim;
    logic            walk_done, out_free;

    assign n_lim = (32'(i_box_count) > MAX_BOXES) ? NW'(MAX_BOXES) : NW'(i_box_count);
    assign o_rd_en   = (r_state == S_WALK) && (r_bidx < n_lim);
    assign o_rd_addr = r_bidx[AW-1:0];
    assign walk_done = (r_state == S_WALK) && !(r_bidx < n_lim) && !r_eval;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd_dp.axis = r_axis;
        o_cmd_dp.eval = r_eval;
        unique case (r_state)
            S_IDLE:  o_cmd_dp.op = !i_in_valid ? OP_NOP : (i_cmd ? OP_LATCH : OP_LOAD);
            S_MAXD:  o_cmd_dp.op = OP_MAXD;
            S_CNT:   o_cmd_dp.op = i_stat.cnt_done ? OP_DIVINIT : OP_CNT;
            S_DIV:   o_cmd_dp.op = OP_DIV;
            S_MUL:   o_cmd_dp.op = OP_MUL;
            S_ADD:   o_cmd_dp.op = OP_ADD;
            S_FLOOR: o_cmd_dp.op = OP_FLOOR;
            S_CEIL:  o_cmd_dp.op = OP_CEIL;
            S_WALK:  o_cmd_dp.op = OP_WALK;
            S_OUT:   o_cmd_dp.op = out_free ? OP_OUT : OP_NOP;
            default: o_cmd_dp.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AX_X;
            r_bidx      <= '0;
            r_eval      <= 1'b0;
            r_div       <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_cmd) begin
                        r_state <= S_MAXD;
                    end
                end
                S_MAXD: r_state <= S_CNT;
                S_CNT: begin
                    if (i_stat.cnt_done) begin
                        r_div   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div <= r_div + DW'(1);
                    if (r_div == DW'(FT_W - 1)) begin
                        r_axis  <= AX_X;
                        r_sub   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    r_bidx  <= '0;
                    r_eval  <= 1'b0;
                    r_state <= (r_axis == AX_Y) ? S_FLOOR : S_WALK;
                end
                S_FLOOR: r_state <= S_CEIL;
                S_CEIL:  r_state <= S_WALK;
                S_WALK: begin
                    r_eval <= o_rd_en;
                    if (o_rd_en) begin
                        r_bidx <= r_bidx + NW'(1);
                    end
                    if (walk_done) begin
                        case (r_axis)
                            AX_X: begin
                                r_axis  <= AX_Z;
                                r_state <= S_MUL;
                            end
                            AX_Z: begin
                                r_axis  <= AX_Y;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_axis  <= AX_X;
                                r_sub   <= r_sub + SW'(1);
                                r_state <= (r_sub + SW'(1) == i_steps) ? S_OUT : S_MUL;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/aabb_collision_resolver.sv */
// Top level: configuration registers, controller and datapath of the collision resolver.
//
// Input channel (i_in_valid / o_in_stall) carries load beats (cmd 0) and step beats
// (cmd 1). A load beat writes one box into the table and yields no
// result; the next beat is taken in the following cycle. A step beat yields one
// result beat on the output channel (o_out_valid / i_out_stall).
// A step runs the substep count search, the frame time divide and then S substeps
// (S is the substep count, 1 to MAX_SUBSTEPS), each a move and a box walk per
// axis in the order X, Z, Y, with the floor and ceiling checks before the Y walk;
// each walk covers the N boxes in use and reads the table through one registered
// read port, one box per cycle, three walks per substep.
// One step item is in work at a time; the input is stalled until its result is
// placed in the output register. That register holds the beat while the
// receiver stalls; a finished step waits for it to drain before the input
// opens again.
// Configuration writes are taken in any cycle and take effect at once; write
// them only while no step is in work. Reset returns the registers to their
// defaults and clears the control state; the box table is not cleared and
// must be loaded before it is used.
module aabb_collision_resolver #(
    parameter int MAX_BOXES    = acr_pkg::DEF_MAX_BOXES,
    parameter int MAX_SUBSTEPS = acr_pkg::DEF_MAX_SUBSTEPS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [acr_pkg::IDX_W-1:0]   i_box_index,
    input  logic signed [31:0]          i_first_x,
    input  logic signed [31:0]          i_first_y,
    input  logic signed [31:0]          i_first_z,
    input  logic signed [31:0]          i_second_x,
    input  logic signed [31:0]          i_second_y,
    input  logic signed [31:0]          i_second_z,
    input  logic [acr_pkg::EXT_W-1:0]   i_entity_radius,
    input  logic [acr_pkg::EXT_W-1:0]   i_entity_height,
    input  logic [acr_pkg::FT_W-1:0]    i_frame_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_new_x,
    output logic signed [31:0]          o_new_y,
    output logic signed [31:0]          o_new_z,
    output logic signed [31:0]          o_new_vel_y,
    output logic                        o_grounded,
    output logic                        o_substeps_clamped,
    input  logic                        i_cfg_we,
    input  logic [acr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import acr_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SW = $clog2(MAX_SUBSTEPS + 1);

    logic signed [31:0] r_floor, r_ceiling;
    logic [30:0]        r_subdist, r_tol;
    logic [CNT_W-1:0]   r_boxcnt;

    t_dp_cmd       cmd_dp;
    t_dp_stat      stat;
    logic [SW-1:0] steps;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= RST_FLOOR;
            r_ceiling <= RST_CEILING;
            r_subdist <= RST_SUBDIST;
            r_tol     <= RST_TOL;
            r_boxcnt  <= RST_BOXCNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLOOR:   r_floor   <= i_cfg_data;
                CFG_CEILING: r_ceiling <= i_cfg_data;
                CFG_SUBDIST: r_subdist <= i_cfg_data[30:0];
                CFG_TOL:     r_tol     <= i_cfg_data[30:0];
                CFG_BOXCNT:  r_boxcnt  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    acr_ctrl #(
        .MAX_BOXES(MAX_BOXES), .MAX_SUBSTEPS(MAX_SUBSTEPS), .AW(AW), .SW(SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_box_count (r_boxcnt),
        .i_steps     (steps),
        .i_stat      (stat),
        .o_cmd_dp    (cmd_dp),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    acr_datapath #(
        .MAX_BOXES(MAX_BOXES), .MAX_SUBSTEPS(MAX_SUBSTEPS), .AW(AW), .SW(SW)
    ) u_dp (
        .i_clk              (i_clk),
        .i_cmd_dp           (cmd_dp),
        .o_stat             (stat),
        .o_steps            (steps),
        .i_rd_en            (rd_en),
        .i_rd_addr          (rd_addr),
        .i_floor            (r_floor),
        .i_ceiling          (r_ceiling),
        .i_subdist          (r_subdist),
        .i_tol              (r_tol),
        .i_box_index        (i_box_index),
        .i_first_x          (i_first_x),
        .i_first_y          (i_first_y),
        .i_first_z          (i_first_z),
        .i_second_x         (i_second_x),
        .i_second_y         (i_second_y),
        .i_second_z         (i_second_z),
        .i_entity_radius    (i_entity_radius),
        .i_entity_height    (i_entity_height),
        .i_frame_time       (i_frame_time),
        .o_new_x            (o_new_x),
        .o_new_y            (o_new_y),
        .o_new_z            (o_new_z),
        .o_new_vel_y        (o_new_vel_y),
        .o_grounded         (o_grounded),
        .o_substeps_clamped (o_substeps_clamped)
    );

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_cmd) |=> o_in_stall)
        else $error("step beat accepted without entering work");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_cmd && !o_out_valid) |=> !o_out_valid)
        else $error("load beat produced a result");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a step in work");

endmodule

/* bench/aabb_collision_resolver_tb.sv */
// Testbench for the AABB collision resolver: queued stimulus, random handshakes, self-checking.
module aabb_collision_resolver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acr_pkg::*;

    localparam int NBOX  = DEF_MAX_BOXES;
    localparam int NSUB  = DEF_MAX_SUBSTEPS;
    localparam int LIMIT = 10000000;

    typedef struct {
        logic               cmd;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] fx, fy, fz, sx, sy, sz;
        logic [EXT_W-1:0]   rad, hgt;
        logic [FT_W-1:0]    ft;
    } beat_t;

    typedef struct {
        logic signed [31:0] x, y, z, vy;
        logic               gnd, clp;
    } motion_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_cmd = 1'b0;
    logic [IDX_W-1:0] i_box_index = '0;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [EXT_W-1:0] i_entity_radius = '0, i_entity_height = '0;
    logic [FT_W-1:0] i_frame_time = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_new_x, o_new_y, o_new_z, o_new_vel_y;
    logic o_grounded, o_substeps_clamped;
    logic i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    aabb_collision_resolver u_top (.*);

    always #10 i_clk = ~i_clk;

    beat_t   pending_beats[$];
    motion_t motion_fifo[$];
    longint  box_ctr[NBOX][3];
    longint  box_half[NBOX][3];
    longint  floor_lv, ceil_lv, sub_dist, land_tol;
    int      box_cnt;

    int  cycles = 0, mismatches = 0, n_steps = 0, n_loads = 0, n_clamped = 0, n_grounded = 0;
    int  gap_left = 0, stall_left = 0, hold_left = 0, hold_reqs = 0, hold_seen = 0;
    bit  calm = 0;
    logic in_fired = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fl16(longint v);
        if (v >= 0) return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic bit boxed(longint px, longint py, longint pz, longint r, longint h, int i);
        return (px + r > box_ctr[i][0] - box_half[i][0]) && (px - r < box_ctr[i][0] + box_half[i][0])
            && (py + h > box_ctr[i][1] - box_half[i][1]) && (py < box_ctr[i][1] + box_half[i][1])
            && (pz + r > box_ctr[i][2] - box_half[i][2]) && (pz - r < box_ctr[i][2] + box_half[i][2]);
    endfunction

    function automatic void push_out(inout longint px, inout longint py, inout longint pz,
                                     input int ax, input longint r, input longint h, input int n);
        longint c, s, pa;
        for (int i = 0; i < n; i++) begin
            if (boxed(px, py, pz, r, h, i)) begin
                c = box_ctr[i][ax];
                s = box_half[i][ax];
                pa = (ax == 0) ? px : pz;
                pa = (pa < c) ? sat(c - s - r) : sat(c + s + r);
                if (ax == 0) px = pa; else pz = pa;
            end
        end
    endfunction

    function automatic motion_t resolve_step(beat_t b);
        longint px, py, pz, vx, vy, vz, r, h, ft, vmax, md, sd, dt, prev, top, bot;
        int n, steps;
        bit gnd, clp;
        motion_t m;
        px = b.fx; py = b.fy; pz = b.fz;
        vx = b.sx; vy = b.sy; vz = b.sz;
        r = b.rad; h = b.hgt; ft = b.ft;
        n = (box_cnt > NBOX) ? NBOX : box_cnt;
        sd = (sub_dist < 1) ? 1 : sub_dist;
        gnd = 0; clp = 0;
        vmax = (vx < 0) ? -vx : vx;
        if ((vy < 0 ? -vy : vy) > vmax) vmax = (vy < 0) ? -vy : vy;
        if ((vz < 0 ? -vz : vz) > vmax) vmax = (vz < 0) ? -vz : vz;
        md = (vmax * ft) >>> 16;
        steps = 1;
        if (md > sd) begin
            if ((md + sd - 1) / sd > NSUB) begin
                steps = NSUB;
                clp = 1;
            end else begin
                steps = int'((md + sd - 1) / sd);
            end
        end
        dt = ft / steps;
        for (int s = 0; s < steps; s++) begin
            px = sat(px + fl16(vx * dt));
            push_out(px, py, pz, 0, r, h, n);
            pz = sat(pz + fl16(vz * dt));
            push_out(px, py, pz, 2, r, h, n);
            prev = py;
            py = sat(py + fl16(vy * dt));
            gnd = 0;
            if (py <= floor_lv) begin
                py = floor_lv;
                vy = 0;
                gnd = 1;
            end
            if (py + h >= ceil_lv) begin
                py = sat(ceil_lv - h);
                if (vy > 0) vy = 0;
            end
            for (int i = 0; i < n; i++) begin
                if (boxed(px, py, pz, r, h, i)) begin
                    top = box_ctr[i][1] + box_half[i][1];
                    bot = box_ctr[i][1] - box_half[i][1];
                    if (vy <= 0 && prev >= top - land_tol) begin
                        py = sat(top);
                        vy = 0;
                        gnd = 1;
                    end else if (vy > 0 && prev + h <= bot + land_tol) begin
                        py = sat(bot - h);
                        vy = 0;
                    end
                end
            end
        end
        m.x = px[31:0]; m.y = py[31:0]; m.z = pz[31:0]; m.vy = vy[31:0];
        m.gnd = gnd; m.clp = clp;
        return m;
    endfunction

    // drive input beats
    always @(negedge i_clk) begin
        beat_t b;
        if (i_rst_n && (!i_in_valid || in_fired)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                b = pending_beats.pop_front();
                i_cmd <= b.cmd; i_box_index <= b.idx;
                i_first_x <= b.fx; i_first_y <= b.fy; i_first_z <= b.fz;
                i_second_x <= b.sx; i_second_y <= b.sy; i_second_z <= b.sz;
                i_entity_radius <= b.rad; i_entity_height <= b.hgt; i_frame_time <= b.ft;
                i_in_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // drive output stall, with a long hold on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen++;
            hold_left = 600;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        beat_t b;
        motion_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
        in_fired <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            b.cmd = i_cmd; b.idx = i_box_index;
            b.fx = i_first_x; b.fy = i_first_y; b.fz = i_first_z;
            b.sx = i_second_x; b.sy = i_second_y; b.sz = i_second_z;
            b.rad = i_entity_radius; b.hgt = i_entity_height; b.ft = i_frame_time;
            if (!b.cmd) begin
                n_loads++;
                box_ctr[b.idx][0] = b.fx; box_ctr[b.idx][1] = b.fy; box_ctr[b.idx][2] = b.fz;
                box_half[b.idx][0] = longint'(b.sx) / 2;
                box_half[b.idx][1] = longint'(b.sy) / 2;
                box_half[b.idx][2] = longint'(b.sz) / 2;
            end else begin
                n_steps++;
                motion_fifo.push_back(resolve_step(b));
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (motion_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat at cycle %0d", cycles);
            end else begin
                e = motion_fifo.pop_front();
                n_clamped += e.clp;
                n_grounded += e.gnd;
                if (o_new_x !== e.x || o_new_y !== e.y || o_new_z !== e.z ||
                    o_new_vel_y !== e.vy || o_grounded !== e.gnd ||
                    o_substeps_clamped !== e.clp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch at cycle %0d: exp x=%0d y=%0d z=%0d vy=%0d g=%0b c=%0b",
                                 cycles, e.x, e.y, e.z, e.vy, e.gnd, e.clp);
                        $display("                        got x=%0d y=%0d z=%0d vy=%0d g=%0b c=%0b",
                                 o_new_x, o_new_y, o_new_z, o_new_vel_y, o_grounded,
                                 o_substeps_clamped);
                    end
                end
            end
        end
    end

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            CFG_FLOOR:   floor_lv = longint'(signed'(data));
            CFG_CEILING: ceil_lv = longint'(signed'(data));
            CFG_SUBDIST: sub_dist = longint'(data[30:0]);
            CFG_TOL:     land_tol = longint'(data[30:0]);
            CFG_BOXCNT:  box_cnt = int'(data[CNT_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_in_valid || motion_fifo.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic beat_t step_beat(int fx, int fy, int fz, int vx, int vy, int vz,
                                         int rad, int hgt, int ft);
        beat_t b;
        b.cmd = 1'b1; b.idx = IDX_W'($urandom);
        b.fx = fx; b.fy = fy; b.fz = fz; b.sx = vx; b.sy = vy; b.sz = vz;
        b.rad = EXT_W'(rad); b.hgt = EXT_W'(hgt); b.ft = FT_W'(ft);
        return b;
    endfunction

    function automatic int srnd(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic beat_t rand_box();
        beat_t b;
        b.cmd = 1'b0; b.idx = IDX_W'($urandom);
        b.rad = EXT_W'($urandom); b.hgt = EXT_W'($urandom); b.ft = FT_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            b.fx = $urandom; b.fy = $urandom; b.fz = $urandom;
            b.sx = $urandom; b.sy = $urandom; b.sz = $urandom;
        end else begin
            b.fx = srnd(262144); b.fy = srnd(65536); b.fz = srnd(262144);
            b.sx = $urandom_range(6554, 131072);
            b.sy = $urandom_range(6554, 131072);
            b.sz = $urandom_range(6554, 131072);
        end
        return b;
    endfunction

    function automatic beat_t rand_step();
        beat_t b;
        if ($urandom_range(0, 6) == 0) begin
            b = step_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
        end else begin
            b = step_beat(srnd(196608), srnd(65536), srnd(196608),
                          srnd(262144), srnd(262144), srnd(262144),
                          $urandom_range(6554, 32768), $urandom_range(32768, 131072),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(500, 12000));
        end
        return b;
    endfunction

    initial begin
        int nitems;
        beat_t b;
        floor_lv = RST_FLOOR; ceil_lv = RST_CEILING;
        sub_dist = RST_SUBDIST; land_tol = RST_TOL; box_cnt = RST_BOXCNT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, empty box table: floor, ceiling, zero frame, clamp, extremes
        pending_beats.push_back(step_beat(0, 0, 0, 0, -65536, 0, 6554, 65536, 16384));
        pending_beats.push_back(step_beat(0, 0, 0, 0, 655360, 0, 6554, 65536, 16384));
        pending_beats.push_back(step_beat(100, 200, 300, 5000, 5000, 5000, 0, 0, 0));
        pending_beats.push_back(step_beat(0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 65535));
        pending_beats.push_back(step_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                          24'hffffff, 24'hffffff, 65535));
        pending_beats.push_back(step_beat(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                          32'sh80000000, 32'sh80000000, 32'sh80000000,
                                          24'hffffff, 24'hffffff, 65535));
        pending_beats.push_back(step_beat(0, -88474, 0, 0, 0, 0, 0, 176948, 1000));
        wait_idle();

        for (int i = 0; i < NBOX; i++) begin
            b = rand_box();
            b.idx = IDX_W'(i);
            pending_beats.push_back(b);
        end
        // slot 0: a floor slab; slot 1: a low ceiling; slot 2: negative size
        b = step_beat(0, -32768, 0, 131072, 65536, 131072, 0, 0, 0); b.cmd = 1'b0; b.idx = 0;
        pending_beats.push_back(b);
        b = step_beat(0, 98304, 0, 131072, 32768, 131072, 0, 0, 0); b.cmd = 1'b0; b.idx = 1;
        pending_beats.push_back(b);
        b = step_beat(262144, 0, 0, -65535, -65535, -65535, 0, 0, 0); b.cmd = 1'b0; b.idx = 2;
        pending_beats.push_back(b);
        wait_idle();
        cfg_write(CFG_BOXCNT, 3);
        cfg_write(CFG_TOL, 0);
        // falling to the slab top, rising below the low box, at rest, moves along x and z
        pending_beats.push_back(step_beat(0, 6554, 0, 0, -65536, 0, 6554, 32768, 6554));
        pending_beats.push_back(step_beat(0, 30000, 0, 0, 131072, 0, 6554, 32768, 6554));
        pending_beats.push_back(step_beat(0, 20000, 0, 0, 0, 0, 6554, 32768, 1000));
        pending_beats.push_back(step_beat(-80000, 10000, 0, 131072, 0, 0, 6554, 32768, 8000));
        pending_beats.push_back(step_beat(0, 10000, -80000, 0, 0, 131072, 6554, 32768, 8000));
        wait_idle();
        cfg_write(CFG_TOL, 32'h7fffffff);
        pending_beats.push_back(step_beat(0, 0, 0, 0, -6554, 0, 6554, 32768, 6554));
        pending_beats.push_back(step_beat(0, 0, 0, 0, 6554, 0, 6554, 32768, 6554));
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph % 4 == 3);
            cfg_write(CFG_FLOOR, ph == 1 ? 32'h80000000 : srnd(131072) - 65536);
            cfg_write(CFG_CEILING, ph == 1 ? 32'h7fffffff : (ph == 5 ? 32'hfffe0000
                                                         : srnd(131072) + 65536));
            cfg_write(CFG_SUBDIST, ph == 2 ? 32'h0 : (ph == 3 ? 32'hffffffff
                                          : $urandom_range(1000, 20000) | (32'($urandom) & 32'h80000000)));
            cfg_write(CFG_TOL, ph == 4 ? 32'h0 : (ph == 6 ? 32'h7fffffff
                                          : $urandom_range(0, 20000) | (32'($urandom) & 32'h80000000)));
            cfg_write(CFG_BOXCNT, ph == 7 ? NBOX : (ph == 8 ? 100 : $urandom_range(0, 8)));
            nitems = (ph == 7 || ph == 8) ? 10 : 36;
            for (int k = 0; k < nitems; k++)
                pending_beats.push_back($urandom_range(0, 9) < 3 ? rand_box() : rand_step());
            if (ph == 9) begin
                @(posedge i_clk);
                hold_reqs++;
            end
            wait_idle();
        end

        $display("Ran %0d step beats and %0d load beats across 12 random settings phases",
                 n_steps, n_loads);
        $display("Results: %0d substep-clamped, %0d grounded, %0d mismatches",
                 n_clamped, n_grounded, mismatches);
        if (mismatches == 0 && motion_fifo.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/acr_pkg.sv
design/acr_datapath.sv
design/acr_ctrl.sv
design/aabb_collision_resolver.sv
bench/aabb_collision_resolver_tb.sv
